// ----- src/spp_pkg.sv -----
`default_nettype none

package spp_pkg;

   // word format
   localparam int WORD = 32;
   localparam int FRAC = 16;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // coefficient table layout
   localparam int LEFT_XF = 0;
   localparam int RIGHT_XF = 12;
   localparam int LEFT_K = 24;
   localparam int RIGHT_K = 33;
   localparam int XF_N = RIGHT_XF * 2;
   localparam int K_N = (RIGHT_K - LEFT_K) * 2;
   localparam int XF_AW = $clog2(XF_N);
   localparam int K_AW = $clog2(K_N);

   // arithmetic widths
   localparam int PROD_W = 2 * WORD;
   localparam int SUM_W = PROD_W - FRAC + 2;
   localparam int NUM_W = WORD + FRAC + 1;

   // divider pipeline
   localparam int STEP_N = 2;
   localparam int DIV_STAGES = WORD / STEP_N;

   // pipeline stage positions
   localparam int S_IN = 0;
   localparam int S_PROD = 1;
   localparam int S_CAM = 2;
   localparam int S_KPROD = 3;
   localparam int S_H = 4;
   localparam int S_DIV0 = 5;
   localparam int S_OUT = S_DIV0 + DIV_STAGES + 1;
   localparam int NSTG = S_OUT + 1;

   // saturation limits
   localparam logic signed [WORD-1:0] MAX_VAL = {1'b0, {(WORD-1){1'b1}}};
   localparam logic signed [WORD-1:0] MIN_VAL = {1'b1, {(WORD-1){1'b0}}};

   // transaction kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PROJ = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;
   localparam logic [1:0] ST_RSV = 2'd3;

   typedef struct packed {
      logic                   func;
      logic [IDX_W-1:0]       coef_index;
      logic signed [WORD-1:0] coef_value;
      logic signed [WORD-1:0] point_x;
      logic signed [WORD-1:0] point_y;
      logic signed [WORD-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD-1:0] left_norm_x;
      logic signed [WORD-1:0] left_norm_y;
      logic signed [WORD-1:0] left_pix_x;
      logic signed [WORD-1:0] left_pix_y;
      logic signed [WORD-1:0] right_norm_x;
      logic signed [WORD-1:0] right_norm_y;
      logic signed [WORD-1:0] right_pix_x;
      logic signed [WORD-1:0] right_pix_y;
      logic signed [WORD-1:0] left_cam_x;
      logic signed [WORD-1:0] left_cam_y;
      logic signed [WORD-1:0] left_cam_z;
      logic [1:0]             status;
   } rsp_type;

   typedef struct packed {
      logic signed [WORD-1:0] v;
      logic                   of;
   } sat_type;

   typedef struct packed {
      logic [2*WORD-1:0] a;
      logic [WORD-1:0]   ud;
      logic              zero;
      logic              big;
      logic              sgn;
      logic              npos;
      logic              nneg;
   } div_stage_type;

   typedef struct packed {
      logic signed [WORD-1:0] q;
      logic                   zf;
      logic                   of;
   } div_res_type;

   // product with fraction bits dropped, rounding toward minus infinity
   function automatic logic signed [SUM_W-1:0] shr_ext(input logic signed [PROD_W-1:0] p);
      return SUM_W'(p >>> FRAC);
   endfunction

   // clamp a wide sum to one word
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if ((v[SUM_W-1:WORD-1] == '0) || (v[SUM_W-1:WORD-1] == '1)) begin
         r.v = v[WORD-1:0];
         r.of = 1'b0;
      end else begin
         r.v = v[SUM_W-1] ? MIN_VAL : MAX_VAL;
         r.of = 1'b1;
      end
      return r;
   endfunction

   // one restoring division step: remainder in the upper half, quotient shifts in below
   function automatic logic [2*WORD-1:0] div_step(input logic [2*WORD-1:0] a,
                                                  input logic [WORD-1:0] d);
      logic [WORD:0] t;
      logic          ge;
      t = {a[2*WORD-1:WORD], a[WORD-1]};
      ge = (t >= {1'b0, d});
      if (ge) begin
         t = t - {1'b0, d};
      end
      return {t[WORD-1:0], a[WORD-2:0], ge};
   endfunction

endpackage

`default_nettype wire

// ----- src/stereo_pinhole_projection.sv -----
// Stereo pinhole projection.
// One input channel (req_*) carries two kinds of transaction. A load writes one
// Q16.16 word into the coefficient table: two 3x4 camera-from-world transforms
// (slots 0-23) and two 3x3 intrinsic matrices (slots 24-41). A project takes a
// world point and returns one transaction on rsp_*: normalized and pixel
// coordinates for both cameras, the left camera-frame point and a status code.
// A load returns nothing. Coefficients must be loaded before any point uses them.
// Throughput: one transaction per cycle while the receiver takes responses, loads and
// projects mixed freely; a load is seen by every project accepted after it.
// From acceptance a project passes two multiply stages, two sum stages, the
// divider input register, 16 divider stages retiring two quotient bits each,
// and the output register before rsp_valid rises.
// Reset clears all valid bits; the table keeps its contents and holds nothing
// defined until loaded.
// When the receiver stalls, the output register holds its transaction; stages
// behind it keep filling bubbles, so req_ready drops only when every stage is full.
`default_nettype none

module stereo_pinhole_projection (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire spp_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output spp_pkg::rsp_type       rsp_data
);

   typedef struct packed {
      logic                            func;
      logic [spp_pkg::IDX_W-1:0]       coef_index;
      logic signed [spp_pkg::WORD-1:0] coef_value;
   } ld_type;

   typedef struct packed {
      logic signed [spp_pkg::WORD-1:0] x;
      logic signed [spp_pkg::WORD-1:0] y;
      logic signed [spp_pkg::WORD-1:0] z;
      logic                            ovf;
   } side_type;

   logic [spp_pkg::NSTG-1:0] v_ff, v_in, en;

   logic signed [spp_pkg::WORD-1:0] xf_ff [0:spp_pkg::XF_N-1];
   logic signed [spp_pkg::WORD-1:0] k_ff [0:spp_pkg::K_N-1];

   spp_pkg::req_type r1_ff;
   ld_type ld2_ff, ld3_ff;
   logic signed [spp_pkg::WORD-1:0] pt [3];
   logic [spp_pkg::IDX_W-1:0] kidx;

   logic signed [spp_pkg::PROD_W-1:0] p_ff [2][3][3];
   logic signed [spp_pkg::WORD-1:0]   t_ff [2][3];
   spp_pkg::sat_type                  cs [2][3];
   logic signed [spp_pkg::WORD-1:0]   cam_ff [2][3];
   logic                              ovf3_ff, ovf3_in;

   logic signed [spp_pkg::PROD_W-1:0] kp_ff [2][3][3];
   logic signed [spp_pkg::WORD-1:0]   cam4_ff [2][3];
   logic                              ovf4_ff;

   spp_pkg::sat_type                  hs [2][3];
   logic signed [spp_pkg::WORD-1:0]   h_ff [2][3];
   logic signed [spp_pkg::WORD-1:0]   cam5_ff [2][3];
   logic                              ovf5_ff, ovf5_in;

   spp_pkg::div_res_type dres [2][4];
   side_type side_ff [0:spp_pkg::DIV_STAGES];
   spp_pkg::rsp_type rsp_ff, rsp_in;

   // stage advance: a stage moves when it is empty or the next one moves
   assign en[spp_pkg::NSTG-1] = !v_ff[spp_pkg::NSTG-1] || rsp_ready;
   for (genvar k = 0; k < spp_pkg::NSTG - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   assign req_ready = en[spp_pkg::S_IN];
   assign rsp_valid = v_ff[spp_pkg::S_OUT];
   assign rsp_data = rsp_ff;

   // valid bits; loads drop out after the intrinsic table stage
   always_comb begin
      for (int k = 0; k < spp_pkg::NSTG; k++) begin
         v_in[k] = v_ff[k];
         if (en[k]) begin
            if (k == spp_pkg::S_IN) begin
               v_in[k] = req_valid;
            end else if (k == spp_pkg::S_KPROD) begin
               v_in[k] = v_ff[k-1] && (ld3_ff.func == spp_pkg::FUNC_PROJ);
            end else begin
               v_in[k] = v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_IN]) begin
         r1_ff <= req_data;
      end
   end

   // transform table, written as a load leaves the input stage
   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_PROD] && v_ff[spp_pkg::S_IN] && (r1_ff.func == spp_pkg::FUNC_LOAD)
          && (r1_ff.coef_index < spp_pkg::IDX_W'(spp_pkg::XF_N))) begin
         xf_ff[r1_ff.coef_index[spp_pkg::XF_AW-1:0]] <= r1_ff.coef_value;
      end
   end

   // world point times transform
   always_comb begin
      pt[0] = r1_ff.point_x;
      pt[1] = r1_ff.point_y;
      pt[2] = r1_ff.point_z;
   end

   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_PROD]) begin
         ld2_ff <= '{r1_ff.func, r1_ff.coef_index, r1_ff.coef_value};
         for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
               t_ff[c][r] <= xf_ff[c*spp_pkg::RIGHT_XF + r*4 + 3];
               for (int j = 0; j < 3; j++) begin
                  p_ff[c][r][j] <= spp_pkg::PROD_W'(xf_ff[c*spp_pkg::RIGHT_XF + r*4 + j])
                                 * spp_pkg::PROD_W'(pt[j]);
               end
            end
         end
      end
   end

   // camera-frame point: sum with translation and saturate
   always_comb begin
      logic signed [spp_pkg::SUM_W-1:0] acc;
      ovf3_in = 1'b0;
      for (int c = 0; c < 2; c++) begin
         for (int r = 0; r < 3; r++) begin
            acc = spp_pkg::SUM_W'(t_ff[c][r]);
            for (int j = 0; j < 3; j++) begin
               acc = acc + spp_pkg::shr_ext(p_ff[c][r][j]);
            end
            cs[c][r] = spp_pkg::sat32(acc);
            ovf3_in = ovf3_in | cs[c][r].of;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_CAM]) begin
         ld3_ff <= ld2_ff;
         ovf3_ff <= ovf3_in;
         for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
               cam_ff[c][r] <= cs[c][r].v;
            end
         end
      end
   end

   // intrinsic table, written as a load leaves the camera stage
   assign kidx = ld3_ff.coef_index - spp_pkg::IDX_W'(spp_pkg::LEFT_K);

   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_KPROD] && v_ff[spp_pkg::S_CAM]
          && (ld3_ff.func == spp_pkg::FUNC_LOAD)
          && (ld3_ff.coef_index >= spp_pkg::IDX_W'(spp_pkg::LEFT_K))
          && (ld3_ff.coef_index < spp_pkg::IDX_W'(spp_pkg::LEFT_K + spp_pkg::K_N))) begin
         k_ff[kidx[spp_pkg::K_AW-1:0]] <= ld3_ff.coef_value;
      end
   end

   // intrinsics times camera point
   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_KPROD]) begin
         ovf4_ff <= ovf3_ff;
         for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
               cam4_ff[c][r] <= cam_ff[c][r];
               for (int j = 0; j < 3; j++) begin
                  kp_ff[c][r][j] <= spp_pkg::PROD_W'(k_ff[c*(spp_pkg::K_N/2) + r*3 + j])
                                  * spp_pkg::PROD_W'(cam_ff[c][j]);
               end
            end
         end
      end
   end

   // homogeneous pixel vector
   always_comb begin
      logic signed [spp_pkg::SUM_W-1:0] acc;
      ovf5_in = ovf4_ff;
      for (int c = 0; c < 2; c++) begin
         for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
               acc = acc + spp_pkg::shr_ext(kp_ff[c][r][j]);
            end
            hs[c][r] = spp_pkg::sat32(acc);
            ovf5_in = ovf5_in | hs[c][r].of;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_H]) begin
         ovf5_ff <= ovf5_in;
         for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
               h_ff[c][r] <= hs[c][r].v;
               cam5_ff[c][r] <= cam4_ff[c][r];
            end
         end
      end
   end

   // eight dividers: norm x, norm y, pix x, pix y per camera
   for (genvar c = 0; c < 2; c++) begin : g_cam
      for (genvar j = 0; j < 4; j++) begin : g_div
         if (j < 2) begin : g_norm
            spp_div u_div (
               .clock (clock),
               .en    (en[spp_pkg::S_OUT-1:spp_pkg::S_DIV0]),
               .num   (cam5_ff[c][j]),
               .den   (cam5_ff[c][2]),
               .res   (dres[c][j])
            );
         end else begin : g_pix
            spp_div u_div (
               .clock (clock),
               .en    (en[spp_pkg::S_OUT-1:spp_pkg::S_DIV0]),
               .num   (h_ff[c][j-2]),
               .den   (h_ff[c][2]),
               .res   (dres[c][j])
            );
         end
      end
   end

   // left camera point and overflow flag ride along with the dividers
   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_DIV0]) begin
         side_ff[0] <= '{cam5_ff[0][0], cam5_ff[0][1], cam5_ff[0][2], ovf5_ff};
      end
      for (int i = 1; i <= spp_pkg::DIV_STAGES; i++) begin
         if (en[spp_pkg::S_DIV0 + i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // output register
   always_comb begin
      logic zf, of;
      zf = 1'b0;
      of = side_ff[spp_pkg::DIV_STAGES].ovf;
      for (int c = 0; c < 2; c++) begin
         for (int j = 0; j < 4; j++) begin
            zf = zf | dres[c][j].zf;
            of = of | dres[c][j].of;
         end
      end
      rsp_in.left_norm_x = dres[0][0].q;
      rsp_in.left_norm_y = dres[0][1].q;
      rsp_in.left_pix_x = dres[0][2].q;
      rsp_in.left_pix_y = dres[0][3].q;
      rsp_in.right_norm_x = dres[1][0].q;
      rsp_in.right_norm_y = dres[1][1].q;
      rsp_in.right_pix_x = dres[1][2].q;
      rsp_in.right_pix_y = dres[1][3].q;
      rsp_in.left_cam_x = side_ff[spp_pkg::DIV_STAGES].x;
      rsp_in.left_cam_y = side_ff[spp_pkg::DIV_STAGES].y;
      rsp_in.left_cam_z = side_ff[spp_pkg::DIV_STAGES].z;
      rsp_in.status = zf ? spp_pkg::ST_ZERO : (of ? spp_pkg::ST_OVF : spp_pkg::ST_OK);
   end

   always_ff @(posedge clock) begin
      if (en[spp_pkg::S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[spp_pkg::S_IN] |-> req_ready)
      else $error("input stage empty but not ready");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != spp_pkg::ST_RSV))
      else $error("reserved status code");

   a_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (v_ff[spp_pkg::S_CAM] && en[spp_pkg::S_KPROD] && (ld3_ff.func == spp_pkg::FUNC_LOAD))
      |=> !v_ff[spp_pkg::S_KPROD])
      else $error("load transaction passed the intrinsic stage");

endmodule

`default_nettype wire

// ----- src/spp_div.sv -----
`default_nettype none

module spp_div (
   input  wire logic                                clock,
   input  wire logic [spp_pkg::DIV_STAGES:0]        en,
   input  wire logic signed [spp_pkg::WORD-1:0]     num,
   input  wire logic signed [spp_pkg::WORD-1:0]     den,
   output spp_pkg::div_res_type                     res
);

   spp_pkg::div_stage_type d_ff [0:spp_pkg::DIV_STAGES];
   spp_pkg::div_stage_type s_in [1:spp_pkg::DIV_STAGES];
   spp_pkg::div_stage_type d_in;
   logic [spp_pkg::WORD-1:0]  un;
   logic [spp_pkg::WORD-1:0]  ud;
   logic [spp_pkg::NUM_W-1:0] nn;
   logic [spp_pkg::WORD-1:0]  q;

   // magnitudes, rounding offset and quotient range check
   always_comb begin
      un = num[spp_pkg::WORD-1] ? spp_pkg::WORD'(-num) : spp_pkg::WORD'(num);
      ud = den[spp_pkg::WORD-1] ? spp_pkg::WORD'(-den) : spp_pkg::WORD'(den);
      nn = {1'b0, un, {spp_pkg::FRAC{1'b0}}} + spp_pkg::NUM_W'(ud >> 1);
      d_in.a = {spp_pkg::WORD'(nn[spp_pkg::NUM_W-1:spp_pkg::WORD]),
                nn[spp_pkg::WORD-1:0]};
      d_in.ud = ud;
      d_in.zero = (den == '0);
      d_in.big = (spp_pkg::WORD'(nn[spp_pkg::NUM_W-1:spp_pkg::WORD]) >= ud);
      d_in.sgn = num[spp_pkg::WORD-1] ^ den[spp_pkg::WORD-1];
      d_in.npos = !num[spp_pkg::WORD-1] && (num != '0);
      d_in.nneg = num[spp_pkg::WORD-1];
   end

   // next value of each stage: two restoring steps on the previous one
   always_comb begin
      for (int i = 1; i <= spp_pkg::DIV_STAGES; i++) begin
         s_in[i] = d_ff[i-1];
         s_in[i].a = spp_pkg::div_step(spp_pkg::div_step(d_ff[i-1].a, d_ff[i-1].ud),
                                       d_ff[i-1].ud);
      end
   end

   // quotient pipeline, two bits per stage
   always_ff @(posedge clock) begin
      if (en[0]) begin
         d_ff[0] <= d_in;
      end
      for (int i = 1; i <= spp_pkg::DIV_STAGES; i++) begin
         if (en[i]) begin
            d_ff[i] <= s_in[i];
         end
      end
   end

   // sign, saturation and zero divisor
   always_comb begin
      q = d_ff[spp_pkg::DIV_STAGES].a[spp_pkg::WORD-1:0];
      res.zf = 1'b0;
      res.of = 1'b0;
      if (d_ff[spp_pkg::DIV_STAGES].zero) begin
         res.zf = 1'b1;
         if (d_ff[spp_pkg::DIV_STAGES].npos) begin
            res.q = spp_pkg::MAX_VAL;
         end else if (d_ff[spp_pkg::DIV_STAGES].nneg) begin
            res.q = spp_pkg::MIN_VAL;
         end else begin
            res.q = '0;
         end
      end else if (d_ff[spp_pkg::DIV_STAGES].big) begin
         res.of = 1'b1;
         res.q = d_ff[spp_pkg::DIV_STAGES].sgn ? spp_pkg::MIN_VAL : spp_pkg::MAX_VAL;
      end else if (d_ff[spp_pkg::DIV_STAGES].sgn) begin
         if (q[spp_pkg::WORD-1] && (q[spp_pkg::WORD-2:0] != '0)) begin
            res.of = 1'b1;
            res.q = spp_pkg::MIN_VAL;
         end else begin
            res.q = -q;
         end
      end else begin
         if (q[spp_pkg::WORD-1]) begin
            res.of = 1'b1;
            res.q = spp_pkg::MAX_VAL;
         end else begin
            res.q = q;
         end
      end
   end

endmodule

`default_nettype wire
